// ===== hw/rtl/accel_event_gravity_separator_macros.svh =====
// assertion macros for the accel event gravity separator
// used by the rtl files that carry concurrent checks; no other dependency
`ifndef ACCEL_EVENT_GRAVITY_SEPARATOR_MACROS_SVH
`define ACCEL_EVENT_GRAVITY_SEPARATOR_MACROS_SVH
`ifndef SYNTHESIS
`define AEGS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define AEGS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define AEGS_ASSERT(lbl, clk, rst_n, prop, msg)
`define AEGS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== hw/rtl/aegs_pkg.sv =====
// shared types, codes and constants of the accel event gravity separator
// no dependencies
`default_nettype none

package aegs_pkg;

  localparam int unsigned SAMPLE_WIDTH_DEF    = 16;
  localparam int unsigned ALPHA_FRAC_BITS_DEF = 16;

  localparam int unsigned OP_W       = 3;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned VALUE_W    = 25;
  localparam int unsigned STAMP_W    = 63;
  localparam int unsigned SID_W      = 5;
  localparam int unsigned GRAV_W     = 32;
  localparam int unsigned SAT_IN_W   = 34;
  localparam int unsigned AXES       = 3;
  localparam int unsigned AXIS_W     = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned OUT_DATA_W = 144;

  localparam logic [CFG_DATA_W-1:0] ALPHA_RESET = 16'd52429;

  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 25'sh0FFFFFF;
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = 25'sh1000000;
  // one g of significant motion, 8 fraction bits
  localparam logic signed [VALUE_W-1:0] MOTION_X  = 25'sd256;

  typedef enum logic [OP_W-1:0] {
    OP_X       = 3'd0,
    OP_Y       = 3'd1,
    OP_Z       = 3'd2,
    OP_SYNC    = 3'd3,
    OP_GESTURE = 3'd4,
    OP_FLUSH   = 3'd5
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACCEL        = 3'd0,
    KIND_LINEAR       = 3'd1,
    KIND_MOTION       = 3'd2,
    KIND_FLUSH_DONE   = 3'd3,
    KIND_FLUSH_REJECT = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    CLS_SAMPLE  = 2'd0,
    CLS_SYNC    = 2'd1,
    CLS_GESTURE = 2'd2,
    CLS_FLUSH   = 2'd3
  } cls_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA  = 2'd0,
    CFG_ACCEL  = 2'd1,
    CFG_LINEAR = 2'd2,
    CFG_MOTION = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    cls_e                 cls;
    logic [AXIS_W-1:0]    axis;
    logic [STAMP_W-1:0]   stamp;
    logic [SID_W-1:0]     sid;
  } item_t;

  typedef struct packed {
    logic en_accel;
    logic en_linear;
    logic arm_we;
    logic arm_val;
  } cfg_t;

  typedef struct packed {
    kind_e                      kind;
    logic signed [VALUE_W-1:0]  x_value;
    logic signed [VALUE_W-1:0]  y_value;
    logic signed [VALUE_W-1:0]  z_value;
    logic [STAMP_W-1:0]         stamp;
    logic [SID_W-1:0]           flushed_sensor;
    logic                       last;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/aegs_front.sv =====
// front end: takes input requests, decodes the op and queues the used ones for the back end
// depends on aegs_pkg
`default_nettype none

module aegs_front #(
  parameter int unsigned SAMPLE_WIDTH = aegs_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [aegs_pkg::OP_W-1:0]         op_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0]    sample_i,
  input  wire logic [aegs_pkg::STAMP_W-1:0]      stamp_i,
  input  wire logic [aegs_pkg::SID_W-1:0]        sid_i,
  output logic                                   head_valid_o,
  output aegs_pkg::item_t                        head_o,
  output logic signed [SAMPLE_WIDTH-1:0]         head_sample_o,
  input  wire logic                              pop_i
);

  localparam int unsigned DEPTH = aegs_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  aegs_pkg::item_t                 mem_q [DEPTH];
  logic signed [SAMPLE_WIDTH-1:0]  smp_q [DEPTH];
  logic [PTR_W-1:0]                wr_q, rd_q;
  logic [PTR_W:0]                  cnt_q;

  aegs_pkg::item_t item_d;
  logic            used;
  logic            push;

  // classify; unused ops are taken and dropped here
  always_comb begin
    item_d.axis  = op_i[aegs_pkg::AXIS_W-1:0];
    item_d.stamp = stamp_i;
    item_d.sid   = sid_i;
    item_d.cls   = aegs_pkg::CLS_SAMPLE;
    used         = 1'b1;
    case (op_i)
      aegs_pkg::OP_X, aegs_pkg::OP_Y, aegs_pkg::OP_Z: item_d.cls = aegs_pkg::CLS_SAMPLE;
      aegs_pkg::OP_SYNC:    item_d.cls = aegs_pkg::CLS_SYNC;
      aegs_pkg::OP_GESTURE: item_d.cls = aegs_pkg::CLS_GESTURE;
      aegs_pkg::OP_FLUSH:   item_d.cls = aegs_pkg::CLS_FLUSH;
      default:              used = 1'b0;
    endcase
  end

  assign in_ready_o    = (cnt_q != (PTR_W+1)'(DEPTH));
  assign push          = in_valid_i && in_ready_o && used;
  assign head_valid_o  = (cnt_q != '0);
  assign head_o        = mem_q[rd_q];
  assign head_sample_o = smp_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= wr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + PTR_W'(1);
      end
      cnt_q <= cnt_q + (PTR_W+1)'(push) - (PTR_W+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= item_d;
      smp_q[wr_q] <= sample_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/aegs_back.sv =====
// back end: gravity filter, axis state, report builder and output register
// depends on aegs_pkg and accel_event_gravity_separator_macros.svh
`default_nettype none
`include "accel_event_gravity_separator_macros.svh"

module aegs_back #(
  parameter int unsigned SAMPLE_WIDTH    = aegs_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned ALPHA_FRAC_BITS = aegs_pkg::ALPHA_FRAC_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           head_valid_i,
  input  wire aegs_pkg::item_t                head_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] head_sample_i,
  output logic                                pop_o,
  input  wire logic [ALPHA_FRAC_BITS:0]       alpha_i,
  input  wire aegs_pkg::cfg_t                 cfg_i,
  output logic                                res_valid_o,
  output aegs_pkg::result_t                   res_o,
  input  wire logic                           res_ready_i
);

  localparam int unsigned GW  = aegs_pkg::GRAV_W;
  localparam int unsigned DW  = GW + 1;
  localparam int unsigned PW  = ALPHA_FRAC_BITS + 2 + DW;
  localparam int unsigned SIW = aegs_pkg::SAT_IN_W;
  localparam int unsigned VW  = aegs_pkg::VALUE_W;
  localparam int unsigned AX  = aegs_pkg::AXES;
  localparam int unsigned AXW = aegs_pkg::AXIS_W;
  localparam logic signed [PW-1:0] ROUND_HALF =
    {{(PW-ALPHA_FRAC_BITS){1'b0}}, 1'b1, {(ALPHA_FRAC_BITS-1){1'b0}}};

  function automatic logic signed [VW-1:0] sat_value(input logic signed [SIW-1:0] v);
    logic signed [VW-1:0] r;
    if (v > SIW'(aegs_pkg::VALUE_MAX)) begin
      r = aegs_pkg::VALUE_MAX;
    end else if (v < SIW'(aegs_pkg::VALUE_MIN)) begin
      r = aegs_pkg::VALUE_MIN;
    end else begin
      r = v[VW-1:0];
    end
    return r;
  endfunction

  logic signed [SAMPLE_WIDTH-1:0] latest_q [AX];
  logic signed [GW-1:0]           grav_q   [AX];
  logic signed [VW-1:0]           lin_q    [AX];
  logic                           armed_q, armed_d;
  logic                           phase_q, phase_d;

  logic                           e1_valid_q;
  logic [AXW-1:0]                 e1_axis_q;
  logic signed [GW-1:0]           e1_s8_q;
  logic signed [PW-1:0]           e1_prod_q;

  logic                           out_valid_q;
  aegs_pkg::result_t              out_q, res_d;

  logic signed [GW-1:0]           grav_sel, s8;
  logic signed [DW-1:0]           diff;
  logic signed [PW-1:0]           prod;
  logic signed [PW-1:0]           acc, shifted;
  logic signed [GW-1:0]           grav_new;
  logic signed [DW-1:0]           lin_diff;
  logic signed [VW-1:0]           lin_new;
  logic signed [SIW-1:0]          lat_ext  [AX];
  logic signed [VW-1:0]           accel_val [AX];

  logic hazard, out_free, out_load, lat_we, e1_load, filt_on;

  // filter front half: g' = s + (a * (g - s) + half) >> frac
  always_comb begin
    grav_sel = '0;
    for (int i = 0; i < AX; i++) begin
      if (head_i.axis == AXW'(i)) begin
        grav_sel = grav_q[i];
      end
    end
    s8   = {(GW-8)'(head_sample_i), 8'h00};
    diff = DW'(grav_sel) - DW'(s8);
    prod = $signed({1'b0, alpha_i}) * diff;
  end

  // filter back half from the e1 registers; the result is written in the cycle after the front half
  always_comb begin
    acc      = e1_prod_q + ROUND_HALF;
    shifted  = acc >>> ALPHA_FRAC_BITS;
    grav_new = e1_s8_q + GW'(shifted);
    lin_diff = DW'(e1_s8_q) - DW'(grav_new);
    lin_new  = sat_value(SIW'(lin_diff));
  end

  always_comb begin
    for (int i = 0; i < AX; i++) begin
      lat_ext[i]   = SIW'(latest_q[i]);
      lat_ext[i]   = lat_ext[i] <<< 8;
      accel_val[i] = sat_value(lat_ext[i]);
    end
  end

  assign filt_on  = cfg_i.en_linear || armed_q;
  assign out_free = !out_valid_q || res_ready_i;
  assign hazard   = e1_valid_q &&
                    ((head_i.cls == aegs_pkg::CLS_SAMPLE && head_i.axis == e1_axis_q) ||
                     head_i.cls == aegs_pkg::CLS_SYNC);

  always_comb begin
    pop_o    = 1'b0;
    out_load = 1'b0;
    lat_we   = 1'b0;
    e1_load  = 1'b0;
    phase_d  = phase_q;
    armed_d  = armed_q;
    res_d    = '0;
    res_d.stamp = head_i.stamp;
    if (head_valid_i && !hazard) begin
      case (head_i.cls)
        aegs_pkg::CLS_SAMPLE: begin
          pop_o   = 1'b1;
          lat_we  = 1'b1;
          e1_load = filt_on;
        end
        aegs_pkg::CLS_SYNC: begin
          if (!cfg_i.en_accel && !cfg_i.en_linear) begin
            pop_o = 1'b1;
          end else if (out_free) begin
            out_load = 1'b1;
            if (!phase_q && cfg_i.en_accel) begin
              res_d.kind    = aegs_pkg::KIND_ACCEL;
              res_d.x_value = accel_val[0];
              res_d.y_value = accel_val[1];
              res_d.z_value = accel_val[2];
              res_d.last    = !cfg_i.en_linear;
              if (cfg_i.en_linear) begin
                phase_d = 1'b1;
              end else begin
                pop_o = 1'b1;
              end
            end else begin
              res_d.kind    = aegs_pkg::KIND_LINEAR;
              res_d.x_value = lin_q[0];
              res_d.y_value = lin_q[1];
              res_d.z_value = lin_q[2];
              res_d.last    = 1'b1;
              phase_d       = 1'b0;
              pop_o         = 1'b1;
            end
          end
        end
        aegs_pkg::CLS_GESTURE: begin
          if (out_free) begin
            out_load      = 1'b1;
            res_d.kind    = aegs_pkg::KIND_MOTION;
            res_d.x_value = aegs_pkg::MOTION_X;
            res_d.last    = 1'b1;
            armed_d       = 1'b0;
            pop_o         = 1'b1;
          end
        end
        aegs_pkg::CLS_FLUSH: begin
          if (out_free) begin
            out_load   = 1'b1;
            res_d.kind = (cfg_i.en_accel || cfg_i.en_linear || armed_q) ?
                         aegs_pkg::KIND_FLUSH_DONE : aegs_pkg::KIND_FLUSH_REJECT;
            res_d.flushed_sensor = head_i.sid;
            res_d.last = 1'b1;
            pop_o      = 1'b1;
          end
        end
        default: pop_o = 1'b1;
      endcase
    end
    if (cfg_i.arm_we) begin
      armed_d = cfg_i.arm_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < AX; i++) begin
        latest_q[i] <= '0;
        grav_q[i]   <= '0;
        lin_q[i]    <= '0;
      end
      armed_q     <= 1'b0;
      phase_q     <= 1'b0;
      e1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      for (int i = 0; i < AX; i++) begin
        if (lat_we && head_i.axis == AXW'(i)) begin
          latest_q[i] <= head_sample_i;
        end
        if (e1_valid_q && e1_axis_q == AXW'(i)) begin
          grav_q[i] <= grav_new;
          lin_q[i]  <= lin_new;
        end
      end
      armed_q    <= armed_d;
      phase_q    <= phase_d;
      e1_valid_q <= e1_load;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (e1_load) begin
      e1_axis_q <= head_i.axis;
      e1_s8_q   <= s8;
      e1_prod_q <= prod;
    end
    if (out_load) begin
      out_q <= res_d;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  `AEGS_ASSERT_NEVER(a_same_axis_raw, clk_i, rst_ni, e1_valid_q && pop_o && head_i.cls == aegs_pkg::CLS_SAMPLE && head_i.axis == e1_axis_q, "sample issued over pending gravity write")
  `AEGS_ASSERT(a_sync_waits, clk_i, rst_ni, e1_valid_q && head_valid_i && head_i.cls == aegs_pkg::CLS_SYNC |-> !out_load && !pop_o, "sync read stale linear values")
  `AEGS_ASSERT(a_phase_sync, clk_i, rst_ni, phase_q |-> head_valid_i && head_i.cls == aegs_pkg::CLS_SYNC && cfg_i.en_linear, "second report phase without pending sync")
  `AEGS_ASSERT(a_gesture_disarm, clk_i, rst_ni, pop_o && head_i.cls == aegs_pkg::CLS_GESTURE && !cfg_i.arm_we |=> !armed_q, "gesture left motion armed")
  `AEGS_ASSERT(a_no_overwrite, clk_i, rst_ni, out_load |-> !out_valid_q || res_ready_i, "result register overwritten")

endmodule

`default_nettype wire

// ===== hw/rtl/accel_event_gravity_separator.sv =====
// top level of the accel event gravity separator: ports, config registers, front and back
// depends on aegs_pkg, aegs_front and aegs_back
//
//   channel   direction  tdata (low bit up)                               tuser  tlast
//   s_axis    in         sample, event_time, sensor_id, zero pad          op     -
//   m_axis    out        x_value, y_value, z_value, stamp, flushed_sensor kind   last
//   cfg       in         write enable, register index, write data         -      -
//
// one request per cycle in while the queue has room; results leave through a registered output stage
// a filtered axis sample stalls the next request when that is a sample on the same axis
// or a sync: the gravity write trails the registered filter multiplier
// a sync with both reports enabled holds the back end for its accel report and then its linear report
// a four-entry queue splits front and back; s_axis_tready_o drops only when it is full
// reset clears all state but the queue entries and the e1 and output data registers at once, no clearing pass
`default_nettype none

module accel_event_gravity_separator #(
  parameter int unsigned SAMPLE_WIDTH    = aegs_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned ALPHA_FRAC_BITS = aegs_pkg::ALPHA_FRAC_BITS_DEF,
  localparam int unsigned IN_DATA_W =
    ((SAMPLE_WIDTH + aegs_pkg::STAMP_W + aegs_pkg::SID_W + 7) / 8) * 8
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 s_axis_tvalid_i,
  output logic                                      s_axis_tready_o,
  // sample, event_time, sensor_id
  input  wire logic [IN_DATA_W-1:0]                 s_axis_tdata_i,
  // op
  input  wire logic [aegs_pkg::OP_W-1:0]            s_axis_tuser_i,
  output logic                                      m_axis_tvalid_o,
  input  wire logic                                 m_axis_tready_i,
  // x_value, y_value, z_value, stamp, flushed_sensor
  output logic [aegs_pkg::OUT_DATA_W-1:0]           m_axis_tdata_o,
  // kind
  output logic [aegs_pkg::KIND_W-1:0]               m_axis_tuser_o,
  output logic                                      m_axis_tlast_o,
  input  wire logic                                 cfg_we_i,
  input  wire logic [aegs_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [aegs_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int unsigned AW = ALPHA_FRAC_BITS + 1;
  localparam int unsigned CW = (AW > aegs_pkg::CFG_DATA_W) ? AW : aegs_pkg::CFG_DATA_W;
  localparam logic [CW-1:0] ALPHA_ONE = CW'(1) << ALPHA_FRAC_BITS;
  localparam logic [AW-1:0] ALPHA_RST_SAT =
    (CW'(aegs_pkg::ALPHA_RESET) > ALPHA_ONE) ? AW'(ALPHA_ONE) : AW'(aegs_pkg::ALPHA_RESET);
  localparam int unsigned ST_LO  = SAMPLE_WIDTH;
  localparam int unsigned SID_LO = SAMPLE_WIDTH + aegs_pkg::STAMP_W;

  logic [AW-1:0]   alpha_q, alpha_d;
  logic [CW-1:0]   data_ext;
  logic            en_accel_q, en_linear_q;
  aegs_pkg::cfg_t  cfg;

  logic                           head_valid, pop;
  aegs_pkg::item_t                head;
  logic signed [SAMPLE_WIDTH-1:0] head_sample;
  aegs_pkg::result_t              res;

  // alpha above one saturates at write time
  always_comb begin
    data_ext = CW'(cfg_data_i);
    alpha_d  = (data_ext > ALPHA_ONE) ? AW'(ALPHA_ONE) : AW'(data_ext);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q     <= ALPHA_RST_SAT;
      en_accel_q  <= 1'b0;
      en_linear_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        aegs_pkg::CFG_ALPHA:  alpha_q     <= alpha_d;
        aegs_pkg::CFG_ACCEL:  en_accel_q  <= cfg_data_i[0];
        aegs_pkg::CFG_LINEAR: en_linear_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg.en_accel  = en_accel_q;
  assign cfg.en_linear = en_linear_q;
  assign cfg.arm_we    = cfg_we_i && (cfg_idx_i == aegs_pkg::CFG_MOTION);
  assign cfg.arm_val   = cfg_data_i[0];

  aegs_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .op_i          (s_axis_tuser_i),
    .sample_i      ($signed(s_axis_tdata_i[SAMPLE_WIDTH-1:0])),
    .stamp_i       (s_axis_tdata_i[ST_LO +: aegs_pkg::STAMP_W]),
    .sid_i         (s_axis_tdata_i[SID_LO +: aegs_pkg::SID_W]),
    .head_valid_o  (head_valid),
    .head_o        (head),
    .head_sample_o (head_sample),
    .pop_i         (pop)
  );

  aegs_back #(
    .SAMPLE_WIDTH    (SAMPLE_WIDTH),
    .ALPHA_FRAC_BITS (ALPHA_FRAC_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .head_sample_i (head_sample),
    .pop_o         (pop),
    .alpha_i       (alpha_q),
    .cfg_i         (cfg),
    .res_valid_o   (m_axis_tvalid_o),
    .res_o         (res),
    .res_ready_i   (m_axis_tready_i)
  );

  assign m_axis_tdata_o = {1'b0, res.flushed_sensor, res.stamp,
                           res.z_value, res.y_value, res.x_value};
  assign m_axis_tuser_o = res.kind;
  assign m_axis_tlast_o = res.last;

endmodule

`default_nettype wire

// ===== tb/accel_event_gravity_separator_checker.sv =====
`timescale 1ns / 1ps
// checker for the accel event gravity separator: follows config writes, predicts the
// reports of every accepted request and compares them in order with the m_axis results
// depends on aegs_pkg only
module accel_event_gravity_separator_checker
  import aegs_pkg::*;
#(
  parameter int unsigned IN_DATA_W = ((SAMPLE_WIDTH_DEF + STAMP_W + SID_W + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  input  logic                  s_axis_tready_i,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  input  logic [OP_W-1:0]       s_axis_tuser_i,
  input  logic                  m_axis_tvalid_i,
  input  logic                  m_axis_tready_i,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata_i,
  input  logic [KIND_W-1:0]     m_axis_tuser_i,
  input  logic                  m_axis_tlast_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned           pending_o,
  output int unsigned           errors_o
);

  localparam int unsigned SW       = SAMPLE_WIDTH_DEF;
  localparam int unsigned STAMP_LO = 3 * VALUE_W;
  localparam int unsigned SID_LO   = STAMP_LO + STAMP_W;
  localparam longint      UNITY    = longint'(1) << ALPHA_FRAC_BITS_DEF;
  localparam longint      HALF     = UNITY >>> 1;
  localparam int unsigned REPORT_LIMIT = 10;

  logic [CFG_DATA_W-1:0]     alpha;
  logic                      en_accel;
  logic                      en_linear;
  logic                      armed;
  logic signed [SW-1:0]      latest [AXES];
  longint                    gravity [AXES];
  logic signed [VALUE_W-1:0] linear [AXES];
  result_t                   awaited_reports [$];
  int unsigned               miss_count = 0;

  function automatic logic signed [VALUE_W-1:0] clamp_value(longint v);
    if (v > longint'(VALUE_MAX)) return VALUE_MAX;
    if (v < longint'(VALUE_MIN)) return VALUE_MIN;
    return VALUE_W'(v);
  endfunction

  function automatic string show(result_t r);
    return $sformatf("kind %0d x %0d y %0d z %0d stamp %0d sensor %0d last %0b",
                     r.kind, r.x_value, r.y_value, r.z_value, r.stamp,
                     r.flushed_sensor, r.last);
  endfunction

  task automatic queue_report(kind_e kind, logic signed [VALUE_W-1:0] x,
                              logic signed [VALUE_W-1:0] y, logic signed [VALUE_W-1:0] z,
                              logic [STAMP_W-1:0] stamp, logic [SID_W-1:0] sid,
                              logic last);
    result_t r;
    r.kind           = kind;
    r.x_value        = x;
    r.y_value        = y;
    r.z_value        = z;
    r.stamp          = stamp;
    r.flushed_sensor = sid;
    r.last           = last;
    awaited_reports.push_back(r);
  endtask

  task automatic predict_reports(logic [OP_W-1:0] op, logic signed [SW-1:0] smp,
                                 logic [STAMP_W-1:0] t, logic [SID_W-1:0] sid);
    longint      s8;
    longint      a;
    longint      acc;
    int unsigned ax;
    s8 = longint'(smp) * 256;
    case (op)
      OP_X, OP_Y, OP_Z: begin
        ax = op;
        latest[ax] = smp;
        // low-pass gravity, rounded to nearest with ties up
        if (en_linear || armed) begin
          a = alpha;
          if (a > UNITY) a = UNITY;
          acc = a * gravity[ax] + (UNITY - a) * s8 + HALF;
          gravity[ax] = acc >>> ALPHA_FRAC_BITS_DEF;
          linear[ax] = clamp_value(s8 - gravity[ax]);
        end
      end
      OP_SYNC: begin
        if (en_accel)
          queue_report(KIND_ACCEL, clamp_value(longint'(latest[0]) * 256),
                       clamp_value(longint'(latest[1]) * 256),
                       clamp_value(longint'(latest[2]) * 256), t, '0, !en_linear);
        if (en_linear)
          queue_report(KIND_LINEAR, linear[0], linear[1], linear[2], t, '0, 1'b1);
      end
      OP_GESTURE: begin
        armed = 1'b0;
        queue_report(KIND_MOTION, MOTION_X, '0, '0, t, '0, 1'b1);
      end
      OP_FLUSH: begin
        if (en_accel || en_linear || armed)
          queue_report(KIND_FLUSH_DONE, '0, '0, '0, t, sid, 1'b1);
        else
          queue_report(KIND_FLUSH_REJECT, '0, '0, '0, t, sid, 1'b1);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      alpha     = ALPHA_RESET;
      en_accel  = 1'b0;
      en_linear = 1'b0;
      armed     = 1'b0;
      for (int i = 0; i < AXES; i++) begin
        latest[i]  = '0;
        gravity[i] = 0;
        linear[i]  = '0;
      end
      awaited_reports.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_ALPHA:  alpha     = cfg_data_i;
          CFG_ACCEL:  en_accel  = cfg_data_i[0];
          CFG_LINEAR: en_linear = cfg_data_i[0];
          CFG_MOTION: armed     = cfg_data_i[0];
          default: ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        predict_reports(s_axis_tuser_i, s_axis_tdata_i[SW-1:0],
                        s_axis_tdata_i[SW+STAMP_W-1:SW],
                        s_axis_tdata_i[SW+STAMP_W+SID_W-1:SW+STAMP_W]);
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.kind           = kind_e'(m_axis_tuser_i);
        got.x_value        = m_axis_tdata_i[VALUE_W-1:0];
        got.y_value        = m_axis_tdata_i[2*VALUE_W-1:VALUE_W];
        got.z_value        = m_axis_tdata_i[3*VALUE_W-1:2*VALUE_W];
        got.stamp          = m_axis_tdata_i[SID_LO-1:STAMP_LO];
        got.flushed_sensor = m_axis_tdata_i[SID_LO+SID_W-1:SID_LO];
        got.last           = m_axis_tlast_i;
        if (awaited_reports.size() == 0) begin
          if (miss_count < REPORT_LIMIT)
            $display("%t unexpected result: %s", $time, show(got));
          miss_count++;
        end else begin
          want = awaited_reports.pop_front();
          if (got.kind !== want.kind || got.x_value !== want.x_value ||
              got.y_value !== want.y_value || got.z_value !== want.z_value ||
              got.stamp !== want.stamp || got.flushed_sensor !== want.flushed_sensor ||
              got.last !== want.last) begin
            if (miss_count < REPORT_LIMIT) begin
              $display("%t mismatch, expected: %s", $time, show(want));
              $display("%t mismatch, actual:   %s", $time, show(got));
            end
            miss_count++;
          end
        end
      end
    end
    pending_o <= awaited_reports.size();
    errors_o  <= miss_count;
  end

endmodule

// ===== tb/accel_event_gravity_separator_test.sv =====
`timescale 1ns / 1ps
// testbench top for the accel event gravity separator: clock, reset, request stimulus,
// receiver stalls, watchdog and verdict; depends on aegs_pkg, the block and its checker
module accel_event_gravity_separator_test;
  import aegs_pkg::*;

  localparam int unsigned IN_DATA_W =
    ((SAMPLE_WIDTH_DEF + STAMP_W + SID_W + 7) / 8) * 8;
  localparam logic [OP_W-1:0]       OP_SPARE_LO   = 3'd6;
  localparam logic [OP_W-1:0]       OP_SPARE_HI   = 3'd7;
  localparam logic [STAMP_W-1:0]    STAMP_MAX     = '1;
  localparam logic signed [15:0]    SAMPLE_MAX    = 16'sh7FFF;
  localparam logic signed [15:0]    SAMPLE_MIN    = 16'sh8000;
  localparam int unsigned           SETTLE_CYCLES = 16;
  localparam int unsigned           HOLD_CYCLES   = 150;
  localparam int unsigned           IDLE_LIMIT    = 3000;
  localparam int unsigned           SEGMENTS      = 9;
  localparam int unsigned           SEGMENT_ITEMS = 60;

  logic                  clk;
  logic                  rst_n;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [OP_W-1:0]       s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [KIND_W-1:0]     m_tuser;
  logic                  m_tlast;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int unsigned           pending;
  int unsigned           errors;
  int unsigned           send_idle_pct = 0;
  int unsigned           recv_idle_pct = 0;
  logic                  hold_req = 1'b0;

  accel_event_gravity_separator dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  accel_event_gravity_separator_checker report_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tuser_i  (m_tuser),
    .m_axis_tlast_i  (m_tlast),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .pending_o       (pending),
    .errors_o        (errors)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, plus one long hold-off once requested
  initial begin
    int unsigned held;
    held = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && held < HOLD_CYCLES) begin
        m_tready = 1'b0;
        held++;
      end else begin
        m_tready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) quiet = 0;
      else quiet++;
    end
    $display("[accel_event_gravity_separator] ERROR");
    $finish;
  end

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return 16'(int'($urandom_range(64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [STAMP_W-1:0] pick_stamp();
    case ($urandom_range(19))
      0: return '0;
      1: return STAMP_MAX;
      default: return STAMP_W'({$urandom, $urandom});
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_alpha();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return ALPHA_RESET;
      3: return 16'h8000;
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  task automatic push_event(logic [OP_W-1:0] op, logic signed [15:0] smp,
                            logic [STAMP_W-1:0] t, logic [SID_W-1:0] sid);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = IN_DATA_W'({sid, t, smp});
    s_tuser  = op;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // sample writes give no result, so leave room for the trailing gravity update
  task automatic settle();
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] v);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = v;
    @(negedge clk);
    cfg_we   = 1'b0;
  endtask

  task automatic configure(logic [CFG_DATA_W-1:0] alpha, logic accel, logic lin,
                           logic motion);
    settle();
    write_reg(CFG_ALPHA, alpha);
    write_reg(CFG_ACCEL, CFG_DATA_W'(accel));
    write_reg(CFG_LINEAR, CFG_DATA_W'(lin));
    write_reg(CFG_MOTION, CFG_DATA_W'(motion));
  endtask

  task automatic random_event();
    int unsigned     r;
    logic [OP_W-1:0] op;
    r = $urandom_range(99);
    if (r < 55) op = OP_W'($urandom_range(OP_Z));
    else if (r < 80) op = OP_SYNC;
    else if (r < 86) op = OP_GESTURE;
    else if (r < 97) op = OP_FLUSH;
    else if ($urandom_range(1) != 0) op = OP_SPARE_LO;
    else op = OP_SPARE_HI;
    push_event(op, pick_sample(), pick_stamp(), SID_W'($urandom));
  endtask

  initial begin
    rst_n    = 1'b0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    cfg_we   = 1'b0;
    cfg_idx  = CFG_ALPHA;
    cfg_data = '0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset settings: flush rejected, silent sync, gesture while unarmed, unused ops
    push_event(OP_FLUSH, SAMPLE_MIN, '0, 5'h1F);
    push_event(OP_SYNC, '0, STAMP_MAX, '0);
    push_event(OP_GESTURE, SAMPLE_MAX, STAMP_MAX, 5'h1F);
    push_event(OP_SPARE_LO, SAMPLE_MAX, STAMP_MAX, 5'h1F);
    push_event(OP_SPARE_HI, SAMPLE_MIN, '0, '0);

    // alpha zero: gravity follows the sample
    configure('0, 1'b1, 1'b1, 1'b0);
    push_event(OP_X, SAMPLE_MAX, '0, '0);
    push_event(OP_Y, SAMPLE_MIN, '0, '0);
    push_event(OP_Z, 16'sd1, '0, '0);
    push_event(OP_SYNC, '0, STAMP_MAX, '0);

    // alpha near one: gravity holds, linear swings to its extremes
    configure('1, 1'b1, 1'b1, 1'b1);
    push_event(OP_X, SAMPLE_MIN, STAMP_MAX, '0);
    push_event(OP_Y, SAMPLE_MAX, STAMP_MAX, '0);
    push_event(OP_Z, -16'sd1, STAMP_MAX, '0);
    push_event(OP_SYNC, '0, '0, '0);
    push_event(OP_FLUSH, '0, pick_stamp(), '0);
    push_event(OP_GESTURE, '0, pick_stamp(), '0);
    push_event(OP_FLUSH, '0, pick_stamp(), 5'd21);

    // motion armed without linear output still runs the filter
    configure(ALPHA_RESET, 1'b1, 1'b0, 1'b1);
    push_event(OP_X, 16'sd1000, pick_stamp(), '0);
    push_event(OP_SYNC, '0, pick_stamp(), '0);
    push_event(OP_GESTURE, '0, pick_stamp(), '0);
    push_event(OP_X, 16'sd2000, pick_stamp(), '0);
    push_event(OP_SYNC, '0, pick_stamp(), '0);

    configure(16'h8000, 1'b0, 1'b0, 1'b0);
    push_event(OP_FLUSH, '0, pick_stamp(), 5'd10);
    push_event(OP_X, 16'sd5, pick_stamp(), '0);
    push_event(OP_SYNC, '0, pick_stamp(), '0);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 24;
          recv_idle_pct = 86;
        end
        1: begin
          send_idle_pct = 86;
          recv_idle_pct = 24;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < SEGMENTS; seg++) begin
        configure(pick_alpha(), $urandom_range(99) < 70, $urandom_range(99) < 70,
                  $urandom_range(99) < 50);
        if (phase == 2 && seg == 3) hold_req = 1'b1;
        repeat (SEGMENT_ITEMS) random_event();
      end
    end

    settle();
    if (errors == 0 && pending == 0)
      $display("[accel_event_gravity_separator] OK");
    else
      $display("[accel_event_gravity_separator] ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/aegs_pkg.sv
hw/rtl/aegs_front.sv
hw/rtl/aegs_back.sv
hw/rtl/accel_event_gravity_separator.sv
tb/accel_event_gravity_separator_checker.sv
tb/accel_event_gravity_separator_test.sv
